FILE: rtl/motor_command_frame_crc32_assert.svh
// Assertion macros shared by the frame builder RTL.
// MCF_ASSERT checks a property on every rising clock edge outside reset.
// MCF_ASSERT_NEVER checks that an expression never holds outside reset.
`ifndef MOTOR_COMMAND_FRAME_CRC32_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_CRC32_ASSERT_SVH

`ifndef SYNTHESIS

`define MCF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("frame builder assertion failed");

`define MCF_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("frame builder forbidden condition seen");

`else

`define MCF_ASSERT(lbl, clk, rstn, prop)

`define MCF_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

FILE: rtl/mcf_pkg.sv
`default_nettype none

package mcf_pkg;

  // frame geometry
  localparam int FRAME_LEN = 34;
  localparam int CRC_SPAN  = 28;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  typedef logic [IDX_W-1:0] idx_t;

  // CRC-32, MSB first, no reflection, no final xor
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_TOP  = 32'h8000_0000;

  // fixed header bytes
  localparam logic [7:0] SYNC0 = 8'hFE;
  localparam logic [7:0] SYNC1 = 8'hEE;

  // byte positions inside the frame
  localparam idx_t POS_SYNC0  = idx_t'(0);
  localparam idx_t POS_SYNC1  = idx_t'(1);
  localparam idx_t POS_ID     = idx_t'(2);
  localparam idx_t POS_MODE   = idx_t'(4);
  localparam idx_t POS_TQ_HI  = idx_t'(12);
  localparam idx_t POS_TQ_LO  = idx_t'(13);
  localparam idx_t POS_SP_HI  = idx_t'(14);
  localparam idx_t POS_SP_LO  = idx_t'(15);
  localparam idx_t POS_PS_B3  = idx_t'(16);
  localparam idx_t POS_PS_B2  = idx_t'(17);
  localparam idx_t POS_PS_B1  = idx_t'(18);
  localparam idx_t POS_PS_B0  = idx_t'(19);
  localparam idx_t POS_KP_HI  = idx_t'(20);
  localparam idx_t POS_KP_LO  = idx_t'(21);
  localparam idx_t POS_KD_HI  = idx_t'(22);
  localparam idx_t POS_KD_LO  = idx_t'(23);
  localparam idx_t POS_CRC3   = idx_t'(30);
  localparam idx_t POS_CRC2   = idx_t'(31);
  localparam idx_t POS_CRC1   = idx_t'(32);
  localparam idx_t POS_CRC0   = idx_t'(33);
  localparam idx_t POS_LAST   = idx_t'(FRAME_LEN - 1);
  localparam idx_t POS_CRC_END = idx_t'(CRC_SPAN);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_e;

  // control from the sequencer to the CRC unit
  typedef struct packed {
    logic init;
    logic update;
  } crc_ctrl_t;

  // one byte through the CRC register, bit by bit, MSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
    logic [31:0] crc;
    logic        fb;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb  = ((crc & CRC_TOP) != '0) ^ data[i];
      crc = {crc[30:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mcf_crc32.sv
`default_nettype none

// Byte-wide CRC-32 register, reused for every byte of the covered span.
module mcf_crc32 (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mcf_pkg::crc_ctrl_t ctrl_i,
  input  wire logic [7:0]        data_i,
  output logic [31:0]            crc_o
);
  import mcf_pkg::*;

  logic [31:0] crc_q, crc_d;

  // init wins over update
  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = CRC_INIT;
    end else if (ctrl_i.update) begin
      crc_d = crc32_byte(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

FILE: rtl/motor_command_frame_crc32.sv
`default_nettype none

// Motor command frame builder with CRC-32.
// A command is transferred at a rising edge with start_i high and busy_o low;
// all command fields are sampled at that edge.
// The block then sends the 34-byte frame, one byte per cycle on frame_byte_o,
// each marked by frame_valid_o for exactly one cycle; frame_last_o flags
// byte 33. Each byte is selected by the sequencer, then registered out.
// A single byte-wide CRC register is stepped once for each of bytes 0..27,
// in the cycle that byte is selected, the cycle before it is shown, so the
// CRC is ready when bytes 30..33 are due.
// busy_o drops during the cycle in which the sequencer selects the last byte,
// so a new command can follow with no gap in output.
// The receiver cannot stall: every strobed byte must be taken in its cycle.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// the strobe; a frame in progress is abandoned.
module motor_command_frame_crc32 (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [7:0]         motor_id_i,
  input  wire logic [7:0]         control_mode_i,
  input  wire logic signed [15:0] torque_q8_i,
  input  wire logic signed [15:0] speed_q7_i,
  input  wire logic signed [31:0] position_cmd_i,
  input  wire logic [15:0]        stiffness_q11_i,
  input  wire logic [15:0]        damping_q10_i,
  output logic                    frame_valid_o,
  output logic [7:0]              frame_byte_o,
  output logic                    frame_last_o
);
  import mcf_pkg::*;

  `include "motor_command_frame_crc32_assert.svh"

  state_e      state_q, state_d;
  idx_t        idx_q, idx_d;
  logic        valid_q, valid_d;
  logic        last_q, last_d;
  logic [7:0]  byte_q, byte_d;
  logic        accept;
  logic [7:0]  cur_byte;
  logic [31:0] crc;
  crc_ctrl_t   crc_ctrl;

  // captured command
  logic [7:0]  id_q, mode_q;
  logic [15:0] tq_q, sp_q, kp_q, kd_q;
  logic [31:0] ps_q;

  assign busy_o = (state_q == ST_SEND) && (idx_q != POS_LAST);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q   <= motor_id_i;
      mode_q <= control_mode_i;
      tq_q   <= torque_q8_i;
      sp_q   <= speed_q7_i;
      ps_q   <= position_cmd_i;
      kp_q   <= stiffness_q11_i;
      kd_q   <= damping_q10_i;
    end
  end

  // byte selector for the current frame position
  always_comb begin
    case (idx_q)
      POS_SYNC0: cur_byte = SYNC0;
      POS_SYNC1: cur_byte = SYNC1;
      POS_ID:    cur_byte = id_q;
      POS_MODE:  cur_byte = mode_q;
      POS_TQ_HI: cur_byte = tq_q[15:8];
      POS_TQ_LO: cur_byte = tq_q[7:0];
      POS_SP_HI: cur_byte = sp_q[15:8];
      POS_SP_LO: cur_byte = sp_q[7:0];
      POS_PS_B3: cur_byte = ps_q[31:24];
      POS_PS_B2: cur_byte = ps_q[23:16];
      POS_PS_B1: cur_byte = ps_q[15:8];
      POS_PS_B0: cur_byte = ps_q[7:0];
      POS_KP_HI: cur_byte = kp_q[15:8];
      POS_KP_LO: cur_byte = kp_q[7:0];
      POS_KD_HI: cur_byte = kd_q[15:8];
      POS_KD_LO: cur_byte = kd_q[7:0];
      POS_CRC3:  cur_byte = crc[31:24];
      POS_CRC2:  cur_byte = crc[23:16];
      POS_CRC1:  cur_byte = crc[15:8];
      POS_CRC0:  cur_byte = crc[7:0];
      default:   cur_byte = 8'h00;
    endcase
  end

  // shared CRC unit
  mcf_crc32 u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (cur_byte),
    .crc_o  (crc)
  );

  // sequencer: next state and output register inputs
  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    valid_d         = 1'b0;
    last_d          = 1'b0;
    byte_d          = byte_q;
    crc_ctrl.init   = accept;
    crc_ctrl.update = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SEND;
          idx_d   = '0;
        end
      end
      ST_SEND: begin
        valid_d         = 1'b1;
        byte_d          = cur_byte;
        last_d          = (idx_q == POS_LAST);
        crc_ctrl.update = (idx_q < POS_CRC_END);
        if (idx_q == POS_LAST) begin
          idx_d   = '0;
          state_d = accept ? ST_SEND : ST_IDLE;
        end else begin
          idx_d = idx_q + idx_t'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign frame_valid_o = valid_q;
  assign frame_byte_o  = byte_q;
  assign frame_last_o  = last_q;

  // checks
  `MCF_ASSERT(a_idle_idx_zero, clk_i, rst_ni, (state_q == ST_IDLE) |-> (idx_q == '0))
  `MCF_ASSERT(a_accept_busy, clk_i, rst_ni, (accept && idx_q != POS_LAST) |=> busy_o)
  `MCF_ASSERT(a_last_marked, clk_i, rst_ni,
              (state_q == ST_SEND && idx_q == POS_LAST) |=> (frame_last_o && frame_valid_o))
  `MCF_ASSERT(a_stream_gapless, clk_i, rst_ni, (busy_o && $past(busy_o)) |-> frame_valid_o)
  `MCF_ASSERT_NEVER(a_last_no_strobe, clk_i, rst_ni, frame_last_o && !frame_valid_o)

endmodule

`default_nettype wire

FILE: tb/motor_command_frame_crc32_test.sv
`timescale 1ns / 100ps

module motor_command_frame_crc32_test;
  import mcf_pkg::*;

  localparam int NUM_DIR     = 12;
  localparam int RAND_PER_PH = 53;
  localparam int WDOG_LIMIT  = 2000;
  localparam int DRAIN_CYC   = 40;

  // one motor command as it is transferred
  typedef struct packed {
    logic [7:0]         id;
    logic [7:0]         mode;
    logic signed [15:0] torque;
    logic signed [15:0] speed;
    logic signed [31:0] pos;
    logic [15:0]        kp;
    logic [15:0]        kd;
  } cmd_t;

  // directed row: command, plus bytes 12..23 typed in where obvious
  typedef struct packed {
    cmd_t        cmd;
    logic        fixed_payload;
    logic [95:0] payload;
  } row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               start_i         = 1'b0;
  logic               busy_o;
  logic [7:0]         motor_id_i      = 8'h00;
  logic [7:0]         control_mode_i  = 8'h00;
  logic signed [15:0] torque_q8_i     = 16'h0000;
  logic signed [15:0] speed_q7_i      = 16'h0000;
  logic signed [31:0] position_cmd_i  = 32'h0000_0000;
  logic [15:0]        stiffness_q11_i = 16'h0000;
  logic [15:0]        damping_q10_i   = 16'h0000;
  logic               frame_valid_o;
  logic [7:0]         frame_byte_o;
  logic               frame_last_o;

  frame_byte_t frame_q[$];
  row_t        dir_tab [NUM_DIR];
  int          idle_pct  = 0;
  int          err_cnt   = 0;
  int          n_cmds    = 0;
  int          n_bytes   = 0;
  int          n_frames  = 0;
  int          wdog_cnt  = 0;

  motor_command_frame_crc32 u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .motor_id_i     (motor_id_i),
    .control_mode_i (control_mode_i),
    .torque_q8_i    (torque_q8_i),
    .speed_q7_i     (speed_q7_i),
    .position_cmd_i (position_cmd_i),
    .stiffness_q11_i(stiffness_q11_i),
    .damping_q10_i  (damping_q10_i),
    .frame_valid_o  (frame_valid_o),
    .frame_byte_o   (frame_byte_o),
    .frame_last_o   (frame_last_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // CRC-32 register, one byte in, MSB first
  function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] r;
    r = acc ^ {d, 24'h0};
    for (int b = 0; b < 8; b++) begin
      r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // lay out one frame and append its bytes to the expected-byte queue
  function automatic void queue_frame(input cmd_t c, input logic fixed_payload,
                                      input logic [95:0] payload);
    logic [7:0]  f [FRAME_LEN];
    logic [31:0] crc;
    frame_byte_t e;
    for (int k = 0; k < FRAME_LEN; k++) begin
      f[k] = 8'h00;
    end
    f[0] = SYNC0;
    f[1] = SYNC1;
    f[2] = c.id;
    f[4] = c.mode;
    {f[12], f[13]} = c.torque;
    {f[14], f[15]} = c.speed;
    {f[16], f[17], f[18], f[19]} = c.pos;
    {f[20], f[21]} = c.kp;
    {f[22], f[23]} = c.kd;
    if (fixed_payload) begin
      for (int k = 0; k < 12; k++) begin
        f[12 + k] = payload[95 - 8 * k -: 8];
      end
    end
    crc = CRC_INIT;
    for (int k = 0; k < CRC_SPAN; k++) begin
      crc = crc_step(crc, f[k]);
    end
    {f[30], f[31], f[32], f[33]} = crc;
    for (int k = 0; k < FRAME_LEN; k++) begin
      e.data = f[k];
      e.last = (k == FRAME_LEN - 1);
      frame_q.push_back(e);
    end
  endfunction

  // corner value of a field of width w, or random
  function automatic logic [31:0] corner_val(input int w);
    logic [31:0] mask;
    mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 1);
    case ($urandom_range(4))
      0: return 32'h0;
      1: return mask;
      2: return 32'h1 << (w - 1);
      3: return mask >> 1;
      default: return $urandom & mask;
    endcase
  endfunction

  // mostly uniform commands, some built from field corners
  function automatic cmd_t rand_cmd();
    cmd_t c;
    if ($urandom_range(99) < 75) begin
      c.id     = 8'($urandom_range(255));
      c.mode   = 8'($urandom_range(255));
      c.torque = 16'($urandom_range(65535));
      c.speed  = 16'($urandom_range(65535));
      c.pos    = $urandom;
      c.kp     = 16'($urandom_range(65535));
      c.kd     = 16'($urandom_range(65535));
    end else begin
      c.id     = 8'(corner_val(8));
      c.mode   = 8'(corner_val(8));
      c.torque = 16'(corner_val(16));
      c.speed  = 16'(corner_val(16));
      c.pos    = corner_val(32);
      c.kp     = 16'(corner_val(16));
      c.kd     = 16'(corner_val(16));
    end
    return c;
  endfunction

  // present one command, with random idle cycles first; returns after the transfer
  task automatic drive_cmd(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    motor_id_i      <= c.id;
    control_mode_i  <= c.mode;
    torque_q8_i     <= c.torque;
    speed_q7_i      <= c.speed;
    position_cmd_i  <= c.pos;
    stiffness_q11_i <= c.kp;
    damping_q10_i   <= c.kd;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    n_cmds++;
  endtask

  // compare each strobed byte with the oldest expected one
  always @(posedge clk_i) begin : byte_check
    frame_byte_t e;
    if (rst_ni && frame_valid_o) begin
      if (frame_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected frame byte: expected none, actual %h last %b",
                 $time, frame_byte_o, frame_last_o);
      end else begin
        e = frame_q.pop_front();
        n_bytes++;
        if (frame_byte_o !== e.data) begin
          err_cnt++;
          $display("%0t: frame_byte mismatch: expected %h, actual %h",
                   $time, e.data, frame_byte_o);
        end
        if (frame_last_o !== e.last) begin
          err_cnt++;
          $display("%0t: frame_last mismatch: expected %b, actual %b",
                   $time, e.last, frame_last_o);
        end
        if (e.last) begin
          n_frames++;
        end
      end
    end
  end

  // watchdog: no transfer and no byte for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || frame_valid_o) begin
        wdog_cnt <= 0;
      end else if (wdog_cnt >= WDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d bytes outstanding", $time, frame_q.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        wdog_cnt <= wdog_cnt + 1;
      end
    end
  end

  initial begin : stimulus
    int   phase_idle [4];
    cmd_t c;
    phase_idle = '{0, 71, 0, 12};

    //            id     mode   torque    speed     position        kp        kd
    dir_tab[0]  = {8'h00, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000,
                   1'b1, 96'h0000_0000_0000_0000_0000_0000};
    dir_tab[1]  = {8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                   1'b1, 96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF};
    // most negative signed fields
    dir_tab[2]  = {8'h00, 8'h00, 16'h8000, 16'h8000, 32'h8000_0000, 16'h0000, 16'h0000,
                   1'b1, 96'h8000_8000_8000_0000_0000_0000};
    // most positive signed fields, full gains
    dir_tab[3]  = {8'h7F, 8'h01, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF,
                   1'b1, 96'h7FFF_7FFF_7FFF_FFFF_FFFF_FFFF};
    dir_tab[4]  = {8'h01, 8'h0A, 16'hFFFF, 16'h0001, 32'h0000_0001, 16'h0001, 16'h8000,
                   1'b1, 96'hFFFF_0001_0000_0001_0001_8000};
    dir_tab[5]  = {8'h55, 8'hAA, 16'h5555, 16'hAAAA, 32'h5555_AAAA, 16'hA5A5, 16'h5A5A,
                   1'b1, 96'h5555_AAAA_5555_AAAA_A5A5_5A5A};
    dir_tab[6]  = {8'h00, 8'hFF, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000,
                   1'b1, 96'h0};
    dir_tab[7]  = {8'hFF, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000,
                   1'b1, 96'h0};
    dir_tab[8]  = {8'h12, 8'h34, 16'h0100, 16'hFF80, 32'h0000_4000, 16'h0800, 16'h0400,
                   1'b0, 96'h0};
    dir_tab[9]  = {8'h80, 8'h05, 16'hFE00, 16'h0C80, 32'hFFFF_C000, 16'h1234, 16'h00FF,
                   1'b0, 96'h0};
    dir_tab[10] = {8'hA5, 8'h0B, 16'h0001, 16'h8001, 32'h0123_4567, 16'h89AB, 16'hCDEF,
                   1'b0, 96'h0};
    dir_tab[11] = {8'h3C, 8'hC3, 16'h7F00, 16'h00FF, 32'hDEAD_BEEF, 16'h0F0F, 16'hF0F0,
                   1'b0, 96'h0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed commands, back to back
    idle_pct = 0;
    for (int i = 0; i < NUM_DIR; i++) begin
      drive_cmd(dir_tab[i].cmd);
      queue_frame(dir_tab[i].cmd, dir_tab[i].fixed_payload, dir_tab[i].payload);
    end

    // random commands over the pacing phases
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int k = 0; k < RAND_PER_PH; k++) begin
        c = rand_cmd();
        drive_cmd(c);
        queue_frame(c, 1'b0, 96'h0);
      end
    end
    start_i <= 1'b0;

    // drain, then watch for stray bytes
    while (frame_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (frame_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected bytes never arrived", $time, frame_q.size());
    end
    $display("Sent %0d commands (%0d directed) under four sender pacing phases,",
             n_cmds, NUM_DIR);
    $display("checked %0d frame bytes in %0d complete frames, %0d errors",
             n_bytes, n_frames, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
